### sv/rhm_pkg.sv
package rhm_pkg;

  localparam int DT_W     = 21;
  localparam int MS_W     = 22;
  localparam int HOUR_W   = 32;
  localparam int COUNT_W  = 32;
  localparam int USAGE_W  = 14;
  // hours * ms-per-hour + ms fits in 54 bits
  localparam int TIME_W   = 54;
  // time scaled by 10000 needs 14 more bits
  localparam int SCALED_W = TIME_W + USAGE_W;

  localparam logic [MS_W-1:0]    MS_PER_HOUR    = 22'd3600000;
  localparam logic [DT_W-1:0]    MAX_ELAPSED_MS = 21'd1800000;
  localparam logic [DT_W-1:0]    FALLBACK_MS    = 21'd10;
  localparam logic [USAGE_W-1:0] USAGE_FULL     = 14'd10000;

  // 10000 = 2^13 + 2^10 + 2^9 + 2^8 + 2^4
  localparam int SCALE_TERMS = 5;
  localparam int DIV_STEPS   = USAGE_W;

  typedef struct packed {
    logic [DT_W-1:0] elapsed_ms;
    logic            running_in;
    logic            trip_reset;
  } in_word_t;

  typedef struct packed {
    logic                 start_pulse;
    logic [COUNT_W-1:0]   total_starts;
    logic [COUNT_W-1:0]   trip_starts;
    logic [HOUR_W-1:0]    total_hours;
    logic [HOUR_W-1:0]    total_run_hours;
    logic [HOUR_W-1:0]    trip_hours;
    logic [HOUR_W-1:0]    trip_run_hours;
    logic [USAGE_W-1:0]   total_usage;
    logic [USAGE_W-1:0]   trip_usage;
    logic [COUNT_W-1:0]   old_trip_starts;
    logic [HOUR_W-1:0]    old_trip_run_hours;
    logic [USAGE_W-1:0]   old_trip_usage;
  } out_word_t;

  typedef struct packed {
    logic [DT_W-1:0] dt;
    logic            running;
    logic            trip_reset;
  } cmd_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_START,
    BK_WAIT,
    BK_PUSH
  } back_state_t;

  typedef enum logic [2:0] {
    DV_IDLE,
    DV_MUL_RUN,
    DV_MUL_ALL,
    DV_CHECK,
    DV_SCALE,
    DV_DIV,
    DV_DONE
  } div_state_t;

  function automatic logic [3:0] scale_shift(input logic [2:0] idx);
    logic [3:0] sh;
    unique case (idx)
      3'd0:    sh = 4'd13;
      3'd1:    sh = 4'd10;
      3'd2:    sh = 4'd9;
      3'd3:    sh = 4'd8;
      3'd4:    sh = 4'd4;
      default: sh = 4'd0;
    endcase
    return sh;
  endfunction

endpackage

### sv/rhm_queue.sv
module rhm_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= din;
    end
  end

endmodule

### sv/rhm_front.sv
module rhm_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  rhm_pkg::in_word_t item,
  output logic              full,
  input  logic              cmd_pop,
  output rhm_pkg::cmd_t     cmd,
  output logic              cmd_empty
);
  import rhm_pkg::*;

  cmd_t                cmd_in;
  logic [$bits(cmd_t)-1:0] cmd_raw;

  // implausible scan time falls back to the nominal tick
  always_comb begin
    cmd_in.running    = item.running_in;
    cmd_in.trip_reset = item.trip_reset;
    if (item.elapsed_ms == '0 || item.elapsed_ms > MAX_ELAPSED_MS) begin
      cmd_in.dt = FALLBACK_MS;
    end else begin
      cmd_in.dt = item.elapsed_ms;
    end
  end

  rhm_queue #(
    .WIDTH($bits(cmd_t)),
    .DEPTH(2)
  ) u_cmd_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .din  (cmd_in),
    .full (full),
    .pop  (cmd_pop),
    .dout (cmd_raw),
    .empty(cmd_empty)
  );

  assign cmd = cmd_t'(cmd_raw);

endmodule

### sv/rhm_usage_div.sv
module rhm_usage_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [rhm_pkg::HOUR_W-1:0]   run_h,
  input  logic [rhm_pkg::MS_W-1:0]     run_ms,
  input  logic [rhm_pkg::HOUR_W-1:0]   all_h,
  input  logic [rhm_pkg::MS_W-1:0]     all_ms,
  output logic                         done,
  output logic [rhm_pkg::USAGE_W-1:0]  usage
);
  import rhm_pkg::*;

  div_state_t          state;
  div_state_t          state_next;
  logic [HOUR_W-1:0]   run_h_q;
  logic [MS_W-1:0]     run_ms_q;
  logic [HOUR_W-1:0]   all_h_q;
  logic [MS_W-1:0]     all_ms_q;
  logic [TIME_W-1:0]   run_val;
  logic [TIME_W-1:0]   all_val;
  logic [SCALED_W-1:0] scaled;
  logic [SCALED_W-1:0] scaled_sum;
  logic [TIME_W-1:0]   rem;
  logic [TIME_W:0]     trial;
  logic [USAGE_W-1:0]  quo;
  logic [3:0]          cnt;
  logic [HOUR_W-1:0]   mul_h;
  logic [MS_W-1:0]     mul_ms;
  logic [TIME_W-1:0]   prod;

  // one multiplier, shared by the run and the calendar time
  always_comb begin
    mul_h  = (state == DV_MUL_RUN) ? run_h_q : all_h_q;
    mul_ms = (state == DV_MUL_RUN) ? run_ms_q : all_ms_q;
    prod   = TIME_W'(mul_h) * TIME_W'(MS_PER_HOUR) + TIME_W'(mul_ms);
  end

  assign scaled_sum = scaled + (SCALED_W'(run_val) << scale_shift(cnt[2:0]));
  assign trial      = {rem, scaled[{3'b000, cnt}]};

  always_comb begin
    state_next = state;
    unique case (state)
      DV_IDLE, DV_DONE: if (start) state_next = DV_MUL_RUN;
      DV_MUL_RUN:       state_next = DV_MUL_ALL;
      DV_MUL_ALL:       state_next = DV_CHECK;
      DV_CHECK: begin
        if (all_val == '0 || run_val >= all_val) begin
          state_next = DV_DONE;
        end else begin
          state_next = DV_SCALE;
        end
      end
      DV_SCALE:         if (cnt == 4'(SCALE_TERMS - 1)) state_next = DV_DIV;
      DV_DIV:           if (cnt == '0) state_next = DV_DONE;
      default:          state_next = DV_IDLE;
    endcase
  end

  always_comb begin
    done  = (state == DV_DONE);
    usage = quo;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= DV_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      DV_IDLE, DV_DONE: begin
        if (start) begin
          run_h_q  <= run_h;
          run_ms_q <= run_ms;
          all_h_q  <= all_h;
          all_ms_q <= all_ms;
        end
      end
      DV_MUL_RUN: run_val <= prod;
      DV_MUL_ALL: all_val <= prod;
      DV_CHECK: begin
        scaled <= '0;
        cnt    <= '0;
        if (all_val == '0) begin
          quo <= '0;
        end else if (run_val >= all_val) begin
          quo <= USAGE_FULL;
        end else begin
          quo <= '0;
        end
      end
      DV_SCALE: begin
        scaled <= scaled_sum;
        if (cnt == 4'(SCALE_TERMS - 1)) begin
          rem <= scaled_sum[SCALED_W-1:DIV_STEPS];
          cnt <= 4'(DIV_STEPS - 1);
        end else begin
          cnt <= cnt + 1'b1;
        end
      end
      DV_DIV: begin
        // restoring step: remainder stays below the calendar time
        if (trial >= {1'b0, all_val}) begin
          rem <= TIME_W'(trial - {1'b0, all_val});
          quo <= {quo[USAGE_W-2:0], 1'b1};
        end else begin
          rem <= trial[TIME_W-1:0];
          quo <= {quo[USAGE_W-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
      end
      default: begin
      end
    endcase
  end

endmodule

### sv/rhm_back.sv
module rhm_back (
  input  logic               clk,
  input  logic               rst,
  input  rhm_pkg::cmd_t      cmd,
  input  logic               cmd_empty,
  output logic               cmd_pop,
  output rhm_pkg::out_word_t res,
  output logic               res_push,
  input  logic               res_full
);
  import rhm_pkg::*;

  function automatic logic [MS_W:0] ms_add(input logic [MS_W-1:0] ms,
                                           input logic [DT_W-1:0] dt);
    logic [MS_W:0] sum;
    sum = {1'b0, ms} + (MS_W + 1)'(dt);
    if (sum >= (MS_W + 1)'(MS_PER_HOUR)) begin
      return {1'b1, MS_W'(sum - (MS_W + 1)'(MS_PER_HOUR))};
    end
    return {1'b0, sum[MS_W-1:0]};
  endfunction

  back_state_t        state;
  back_state_t        state_next;
  logic               upd;
  logic               div_start;
  logic               tot_done;
  logic               trip_done;
  logic [USAGE_W-1:0] tot_div_usage;
  logic [USAGE_W-1:0] trip_div_usage;

  logic [MS_W-1:0]    total_ms;
  logic [HOUR_W-1:0]  total_hours;
  logic [MS_W-1:0]    trip_ms;
  logic [HOUR_W-1:0]  trip_hours;
  logic [MS_W-1:0]    total_run_ms;
  logic [HOUR_W-1:0]  total_run_hours;
  logic [MS_W-1:0]    trip_run_ms;
  logic [HOUR_W-1:0]  trip_run_hours;
  logic [COUNT_W-1:0] total_starts;
  logic [COUNT_W-1:0] trip_starts;
  logic               was_running;
  logic               start_pulse;
  logic [USAGE_W-1:0] total_usage;
  logic [USAGE_W-1:0] last_trip_usage;
  logic [COUNT_W-1:0] saved_trip_starts;
  logic [HOUR_W-1:0]  saved_trip_run_hours;
  logic [USAGE_W-1:0] saved_trip_usage;

  logic [MS_W-1:0]    trip_ms_base;
  logic [HOUR_W-1:0]  trip_hours_base;
  logic [MS_W-1:0]    trip_run_ms_base;
  logic [HOUR_W-1:0]  trip_run_hours_base;
  logic [COUNT_W-1:0] trip_starts_base;
  logic               rising;
  logic [MS_W:0]      tot_acc;
  logic [MS_W:0]      trip_acc;
  logic [MS_W:0]      tot_run_acc;
  logic [MS_W:0]      trip_run_acc;

  // trip reset clears before the update
  always_comb begin
    trip_ms_base        = cmd.trip_reset ? '0 : trip_ms;
    trip_hours_base     = cmd.trip_reset ? '0 : trip_hours;
    trip_run_ms_base    = cmd.trip_reset ? '0 : trip_run_ms;
    trip_run_hours_base = cmd.trip_reset ? '0 : trip_run_hours;
    trip_starts_base    = cmd.trip_reset ? '0 : trip_starts;
    rising              = cmd.running && !was_running;
    tot_acc             = ms_add(total_ms, cmd.dt);
    trip_acc            = ms_add(trip_ms_base, cmd.dt);
    tot_run_acc         = ms_add(total_run_ms, cmd.dt);
    trip_run_acc        = ms_add(trip_run_ms_base, cmd.dt);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE:  if (!cmd_empty) state_next = BK_START;
      BK_START: state_next = BK_WAIT;
      BK_WAIT:  if (tot_done && trip_done) state_next = BK_PUSH;
      BK_PUSH:  if (!res_full) state_next = BK_IDLE;
      default:  state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    upd       = (state == BK_IDLE) && !cmd_empty;
    cmd_pop   = upd;
    div_start = (state == BK_START);
    res_push  = (state == BK_PUSH) && !res_full;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      total_ms             <= '0;
      total_hours          <= '0;
      trip_ms              <= '0;
      trip_hours           <= '0;
      total_run_ms         <= '0;
      total_run_hours      <= '0;
      trip_run_ms          <= '0;
      trip_run_hours       <= '0;
      total_starts         <= '0;
      trip_starts          <= '0;
      was_running          <= 1'b0;
      start_pulse          <= 1'b0;
      total_usage          <= '0;
      last_trip_usage      <= '0;
      saved_trip_starts    <= '0;
      saved_trip_run_hours <= '0;
      saved_trip_usage     <= '0;
    end else begin
      if (upd) begin
        if (cmd.trip_reset) begin
          saved_trip_starts    <= trip_starts;
          saved_trip_run_hours <= trip_run_hours;
          saved_trip_usage     <= last_trip_usage;
        end
        total_ms    <= tot_acc[MS_W-1:0];
        total_hours <= total_hours + HOUR_W'(tot_acc[MS_W]);
        trip_ms     <= trip_acc[MS_W-1:0];
        trip_hours  <= trip_hours_base + HOUR_W'(trip_acc[MS_W]);
        if (cmd.running) begin
          total_run_ms    <= tot_run_acc[MS_W-1:0];
          total_run_hours <= total_run_hours + HOUR_W'(tot_run_acc[MS_W]);
          trip_run_ms     <= trip_run_acc[MS_W-1:0];
          trip_run_hours  <= trip_run_hours_base + HOUR_W'(trip_run_acc[MS_W]);
        end else begin
          trip_run_ms     <= trip_run_ms_base;
          trip_run_hours  <= trip_run_hours_base;
        end
        total_starts <= total_starts + COUNT_W'(rising);
        trip_starts  <= trip_starts_base + COUNT_W'(rising);
        was_running  <= cmd.running;
        start_pulse  <= rising;
      end
      if (state == BK_WAIT && tot_done && trip_done) begin
        total_usage     <= tot_div_usage;
        last_trip_usage <= trip_div_usage;
      end
    end
  end

  rhm_usage_div u_total_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .run_h (total_run_hours),
    .run_ms(total_run_ms),
    .all_h (total_hours),
    .all_ms(total_ms),
    .done  (tot_done),
    .usage (tot_div_usage)
  );

  rhm_usage_div u_trip_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .run_h (trip_run_hours),
    .run_ms(trip_run_ms),
    .all_h (trip_hours),
    .all_ms(trip_ms),
    .done  (trip_done),
    .usage (trip_div_usage)
  );

  always_comb begin
    res.start_pulse        = start_pulse;
    res.total_starts       = total_starts;
    res.trip_starts        = trip_starts;
    res.total_hours        = total_hours;
    res.total_run_hours    = total_run_hours;
    res.trip_hours         = trip_hours;
    res.trip_run_hours     = trip_run_hours;
    res.total_usage        = total_usage;
    res.trip_usage         = last_trip_usage;
    res.old_trip_starts    = saved_trip_starts;
    res.old_trip_run_hours = saved_trip_run_hours;
    res.old_trip_usage     = saved_trip_usage;
  end

endmodule

### sv/running_hours_meter.sv
// running hours meter: one input word per scan tick (elapsed ms, running flag,
// trip reset request) gives exactly one result word with start pulse, start
// counters, calendar and running hours (total and trip), usage in hundredths
// of a percent and the trip snapshot taken at the last trip reset. an elapsed
// time of zero or above 1800000 ms counts as 10 ms. between pop of the command
// queue and push of the result the back end updates the counters and then
// waits on the two usage dividers, which run side by side and each do a
// multiply for run time and one for calendar time, 5 shift-add steps scaling
// run time by 10000 and 14 restoring quotient steps; when calendar time is
// zero or run time has caught up with it the divider skips the scaling and
// division. a two-word command queue on the input side and a two-word
// result queue on the output side let the producer and consumer stall on
// their own while the back end works

module running_hours_meter (
  input  logic               clk,
  input  logic               rst,
  // input side
  input  logic               push,
  input  rhm_pkg::in_word_t  item,
  output logic               full,
  // result side
  output logic               empty,
  input  logic               pop,
  output rhm_pkg::out_word_t result
);
  import rhm_pkg::*;

  cmd_t                         cmd;
  logic                         cmd_empty;
  logic                         cmd_pop;
  out_word_t                    res;
  logic                         res_push;
  logic                         res_full;
  logic [$bits(out_word_t)-1:0] res_raw;

  // front end: replaces an implausible scan time and queues the command word
  rhm_front u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .item     (item),
    .full     (full),
    .cmd_pop  (cmd_pop),
    .cmd      (cmd),
    .cmd_empty(cmd_empty)
  );

  // back end: counter update, then both usage divisions
  rhm_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .cmd_empty(cmd_empty),
    .cmd_pop  (cmd_pop),
    .res      (res),
    .res_push (res_push),
    .res_full (res_full)
  );

  // result queue, oldest word shown while not empty
  rhm_queue #(
    .WIDTH($bits(out_word_t)),
    .DEPTH(2)
  ) u_res_queue (
    .clk  (clk),
    .rst  (rst),
    .push (res_push),
    .din  (res),
    .full (res_full),
    .pop  (pop),
    .dout (res_raw),
    .empty(empty)
  );

  assign result = out_word_t'(res_raw);

endmodule

### tb/running_hours_meter_test.sv
module running_hours_meter_test;
  timeunit 1ns;
  timeprecision 1ps;

  import rhm_pkg::*;

  // cycles with no word moving on either side before the run is given up
  localparam int QUIET_LIMIT = 4000;
  // words in the random part, and how many of them at the end run with no idling
  localparam int RANDOM_WORDS = 1600;
  localparam int CALM_WORDS   = 200;

  // keeps its own copy of the meter state, predicts one result word per
  // accepted tick and checks the result words in order
  class hours_meter_board;
    logic [MS_W-1:0]    tot_ms = '0, trip_ms = '0, tot_run_ms = '0, trip_run_ms = '0;
    logic [HOUR_W-1:0]  tot_h = '0, trip_h = '0, tot_run_h = '0, trip_run_h = '0;
    logic [COUNT_W-1:0] tot_starts = '0, trip_starts = '0;
    bit                 was_run = 1'b0;
    logic [USAGE_W-1:0] prev_trip_usage = '0, snap_usage = '0;
    logic [COUNT_W-1:0] snap_starts = '0;
    logic [HOUR_W-1:0]  snap_run_h = '0;
    out_word_t          expected_words[$];
    int                 errors = 0;

    // {carry, new ms} after adding one tick to a ms-within-hour counter
    function logic [MS_W:0] carry_sum(logic [MS_W-1:0] ms, logic [DT_W-1:0] dt);
      logic [MS_W:0] sum;
      sum = {1'b0, ms} + (MS_W + 1)'(dt);
      if (sum >= MS_PER_HOUR) return {1'b1, MS_W'(sum - MS_PER_HOUR)};
      return {1'b0, sum[MS_W-1:0]};
    endfunction

    // run time share of calendar time in hundredths of a percent, truncated
    function logic [USAGE_W-1:0] usage_pct(logic [HOUR_W-1:0] run_h, logic [MS_W-1:0] run_ms,
                                           logic [HOUR_W-1:0] all_h, logic [MS_W-1:0] all_ms);
      logic [SCALED_W-1:0] run_t, all_t, quo;
      run_t = SCALED_W'(run_h) * SCALED_W'(MS_PER_HOUR) + SCALED_W'(run_ms);
      all_t = SCALED_W'(all_h) * SCALED_W'(MS_PER_HOUR) + SCALED_W'(all_ms);
      if (all_t == 0) return '0;
      if (run_t >= all_t) return USAGE_FULL;
      quo = (run_t * SCALED_W'(USAGE_FULL)) / all_t;
      return quo[USAGE_W-1:0];
    endfunction

    function void note_tick(in_word_t w);
      logic [DT_W-1:0] dt;
      logic [MS_W:0]   cs;
      out_word_t       exp_w;
      exp_w = '0;
      dt = w.elapsed_ms;
      // implausible scan time counts as the fallback
      if (dt == 0 || dt > MAX_ELAPSED_MS) dt = FALLBACK_MS;
      // trip reset snapshots before clearing; usage is last tick's value
      if (w.trip_reset) begin
        snap_starts = trip_starts;
        snap_run_h  = trip_run_h;
        snap_usage  = prev_trip_usage;
        trip_starts = '0;
        trip_run_h  = '0;
        trip_run_ms = '0;
        trip_h      = '0;
        trip_ms     = '0;
      end
      cs = carry_sum(tot_ms, dt);  tot_ms  = cs[MS_W-1:0];  tot_h  += cs[MS_W];
      cs = carry_sum(trip_ms, dt); trip_ms = cs[MS_W-1:0]; trip_h += cs[MS_W];
      if (w.running_in) begin
        if (!was_run) begin
          exp_w.start_pulse = 1'b1;
          tot_starts  += 1;
          trip_starts += 1;
        end
        cs = carry_sum(trip_run_ms, dt); trip_run_ms = cs[MS_W-1:0]; trip_run_h += cs[MS_W];
        cs = carry_sum(tot_run_ms, dt);  tot_run_ms  = cs[MS_W-1:0]; tot_run_h  += cs[MS_W];
      end
      was_run = w.running_in;
      prev_trip_usage = usage_pct(trip_run_h, trip_run_ms, trip_h, trip_ms);
      exp_w.total_starts       = tot_starts;
      exp_w.trip_starts        = trip_starts;
      exp_w.total_hours        = tot_h;
      exp_w.total_run_hours    = tot_run_h;
      exp_w.trip_hours         = trip_h;
      exp_w.trip_run_hours     = trip_run_h;
      exp_w.total_usage        = usage_pct(tot_run_h, tot_run_ms, tot_h, tot_ms);
      exp_w.trip_usage         = prev_trip_usage;
      exp_w.old_trip_starts    = snap_starts;
      exp_w.old_trip_run_hours = snap_run_h;
      exp_w.old_trip_usage     = snap_usage;
      expected_words.push_back(exp_w);
    endfunction

    task report_mismatch(string what);
      $display("mismatch at %0t: %s", $realtime, what);
      errors++;
    endtask

    task check_field(string name, logic [63:0] got, logic [63:0] want);
      if (got !== want) report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
    endtask

    task check_word(out_word_t got);
      out_word_t want;
      if (expected_words.size() == 0) begin
        report_mismatch("result word with nothing expected");
        return;
      end
      want = expected_words.pop_front();
      check_field("start_pulse", got.start_pulse, want.start_pulse);
      check_field("total_starts", got.total_starts, want.total_starts);
      check_field("trip_starts", got.trip_starts, want.trip_starts);
      check_field("total_hours", got.total_hours, want.total_hours);
      check_field("total_run_hours", got.total_run_hours, want.total_run_hours);
      check_field("trip_hours", got.trip_hours, want.trip_hours);
      check_field("trip_run_hours", got.trip_run_hours, want.trip_run_hours);
      check_field("total_usage", got.total_usage, want.total_usage);
      check_field("trip_usage", got.trip_usage, want.trip_usage);
      check_field("old_trip_starts", got.old_trip_starts, want.old_trip_starts);
      check_field("old_trip_run_hours", got.old_trip_run_hours, want.old_trip_run_hours);
      check_field("old_trip_usage", got.old_trip_usage, want.old_trip_usage);
    endtask

    function int pending();
      return expected_words.size();
    endfunction
  endclass

  logic      clk;
  logic      rst;
  logic      push;
  in_word_t  item;
  logic      full;
  logic      empty;
  logic      pop;
  out_word_t result;

  hours_meter_board meter = new();

  // chance in percent of an idle burst on either side; zero in stretches
  int unsigned idle_pct = 0;
  // set for the closing part of the run, where nobody idles
  bit          calm = 1'b0;
  int unsigned quiet_cycles = 0;

  running_hours_meter u_dut (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .item   (item),
    .full   (full),
    .empty  (empty),
    .pop    (pop),
    .result (result)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // both handshakes sampled at the edge, before any flop or driver updates
  always @(posedge clk) begin
    if (!rst && push && !full) meter.note_tick(item);
    if (!rst && pop && !empty) meter.check_word(result);
  end

  // give up once nothing has moved for too long
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // result side: pop mostly high, with random stall bursts
  initial begin
    pop = 1'b0;
    @(negedge rst);
    forever begin
      if (!calm && $urandom_range(99, 0) < idle_pct) begin
        pop <= 1'b0;
        repeat ($urandom_range(13, 1)) @(posedge clk);
      end
      pop <= 1'b1;
      @(posedge clk);
    end
  end

  // offer one word, with an optional idle burst first, and wait for acceptance
  task send_word(in_word_t w);
    if (!calm && $urandom_range(99, 0) < idle_pct) begin
      push <= 1'b0;
      repeat ($urandom_range(13, 1)) @(posedge clk);
    end
    push <= 1'b1;
    item <= w;
    do @(posedge clk); while (full);
  endtask

  task drive_tick(input logic [DT_W-1:0] dt, input bit run, input bit trip_rst);
    in_word_t w;
    w.elapsed_ms = dt;
    w.running_in = run;
    w.trip_reset = trip_rst;
    send_word(w);
  endtask

  // sender holds off until every expected result word is back
  task drain_results();
    push <= 1'b0;
    while (meter.pending() != 0) @(posedge clk);
  endtask

  // mostly long scans so hours carry often, some short ones and some bad ones
  function automatic logic [DT_W-1:0] pick_elapsed();
    int unsigned r;
    r = $urandom_range(99, 0);
    if (r < 40) return DT_W'($urandom_range(MAX_ELAPSED_MS, 900000));
    if (r < 60) return DT_W'($urandom_range(2097151, 0));
    if (r < 64) begin
      case ($urandom_range(3, 0))
        0:       return '0;
        1:       return MAX_ELAPSED_MS;
        2:       return DT_W'(MAX_ELAPSED_MS + 1);
        default: return '1;
      endcase
    end
    return DT_W'($urandom_range(5000, 1));
  endfunction

  initial begin
    bit run_now;
    rst  = 1'b1;
    push = 1'b0;
    item = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: elapsed extremes and fallbacks, start edges, hour carry,
    // trip reset snapshots, trip reset on a start edge
    drive_tick('0, 1'b0, 1'b0);
    drive_tick(21'd1, 1'b1, 1'b0);
    drive_tick(MAX_ELAPSED_MS, 1'b1, 1'b0);
    drive_tick(DT_W'(MAX_ELAPSED_MS + 1), 1'b1, 1'b0);
    drive_tick('1, 1'b0, 1'b0);
    drive_tick(MAX_ELAPSED_MS, 1'b1, 1'b0);
    drive_tick(MAX_ELAPSED_MS, 1'b1, 1'b1);
    drive_tick(MAX_ELAPSED_MS, 1'b0, 1'b1);
    drive_tick(21'd1234567, 1'b1, 1'b0);
    drive_tick(21'h100000, 1'b0, 1'b0);
    drive_tick(21'h0aaaaa, 1'b1, 1'b1);
    drive_tick(21'h155555, 1'b1, 1'b0);
    drive_tick(MAX_ELAPSED_MS, 1'b1, 1'b0);
    drive_tick(MAX_ELAPSED_MS, 1'b1, 1'b0);
    drive_tick(MAX_ELAPSED_MS, 1'b1, 1'b0);
    drive_tick(21'd10, 1'b0, 1'b0);
    drive_tick(DT_W'(MAX_ELAPSED_MS - 1), 1'b0, 1'b0);
    drive_tick(21'd2, 1'b1, 1'b1);
    drive_tick('0, 1'b0, 1'b1);
    drain_results();

    // random: running in stretches, occasional trip resets
    run_now = 1'b0;
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      if (i % 64 == 0) begin
        case ($urandom_range(2, 0))
          0:       idle_pct = 0;
          1:       idle_pct = 10;
          default: idle_pct = 40;
        endcase
      end
      if (i == RANDOM_WORDS - CALM_WORDS) calm = 1'b1;
      if (i % 300 == 150) drain_results();
      if ($urandom_range(7, 0) == 0) run_now = ~run_now;
      drive_tick(pick_elapsed(), run_now, $urandom_range(29, 0) == 0);
    end
    push <= 1'b0;

    // let the last words come back, then a little slack for stray results
    while (meter.pending() != 0) @(posedge clk);
    repeat (60) @(posedge clk);

    if (meter.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
